FILE: src/ssalu_pkg.sv
// Package with the types, codes and constants of the saturating signed ALU.
package ssalu_pkg;

  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int DIV_STAGES = 4;
  localparam int STEPS_PER_STAGE = DATA_W / DIV_STAGES;
  localparam int LATENCY = DIV_STAGES + 3;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [DATA_W-1:0] mag_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam word_t WORD_MAX = word_t'(16'sh7FFF);
  localparam word_t WORD_MIN = word_t'(16'sh8000);
  localparam word_t WORD_NEG_ONE = word_t'(16'shFFFF);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_REM = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HIGH    = 2'd1,
    ST_LOW     = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

endpackage

FILE: src/saturating_signed_alu.sv
// Top level of the pipelined saturating 16-bit signed ALU.

// One beat enters at every clock edge where start is high; busy is always low, so the block
// never refuses a beat. Each beat leaves as one cycle of done with result and status; the
// receiver cannot stall and nothing inside ever waits. The latency is set by the divider, a
// restoring divider cut into four stages of four quotient bits each, placed after an input
// register and an operand stage (add, subtract, negate, multiply, divisor and dividend
// magnitudes) and before a final stage that saturates the product and fixes the sign of
// quotient or remainder. All operations share the same latency, so results come out in the
// order the beats went in.
module saturating_signed_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            func,
  input  ssalu_pkg::word_t      operand_a,
  input  ssalu_pkg::word_t      operand_b,
  output logic                  done,
  output ssalu_pkg::word_t      result,
  output logic [1:0]            status
);
  import ssalu_pkg::*;

  typedef struct packed {
    word_t   v;
    status_t st;
  } sat_t;

  typedef struct packed {
    op_t     func;
    word_t   arith;
    status_t arith_st;
    prod_t   prod;
    logic    divz;
    logic    minneg;
    logic    qneg;
    logic    rneg;
    mag_t    rem;
    mag_t    dq;
    mag_t    dvs;
  } pipe_t;

  function automatic sat_t sat_sum(input logic signed [DATA_W:0] s);
    sat_t r;
    if (s[DATA_W] == s[DATA_W-1]) begin
      r.v = s[DATA_W-1:0];
      r.st = ST_OK;
    end else if (!s[DATA_W]) begin
      r.v = WORD_MAX;
      r.st = ST_HIGH;
    end else begin
      r.v = WORD_MIN;
      r.st = ST_LOW;
    end
    return r;
  endfunction

  function automatic sat_t sat_prod(input prod_t p);
    sat_t r;
    if (p > PROD_W'(WORD_MAX)) begin
      r.v = WORD_MAX;
      r.st = ST_HIGH;
    end else if (p < PROD_W'(WORD_MIN)) begin
      r.v = WORD_MIN;
      r.st = ST_LOW;
    end else begin
      r.v = p[DATA_W-1:0];
      r.st = ST_OK;
    end
    return r;
  endfunction

  logic                    in_vld;
  op_t                     in_func;
  word_t                   in_a;
  word_t                   in_b;

  logic                    vld [DIV_STAGES+1];
  pipe_t                   stg [DIV_STAGES+1];
  pipe_t                   stg0_next;
  pipe_t                   div_next [DIV_STAGES];
  logic [DATA_W:0]         rem_sh;
  logic [DATA_W:0]         rem_diff;

  logic signed [DATA_W:0]  ext_a;
  logic signed [DATA_W:0]  ext_b;
  logic signed [DATA_W:0]  raw_sum;
  sat_t                    arith_sat;
  sat_t                    prod_sat;
  sat_t                    fin;
  mag_t                    quo;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start;
    end
    in_func <= op_t'(func);
    in_a <= operand_a;
    in_b <= operand_b;
  end

  assign ext_a = {in_a[DATA_W-1], in_a};
  assign ext_b = {in_b[DATA_W-1], in_b};

  always_comb begin
    unique case (in_func)
      OP_ADD:  raw_sum = ext_a + ext_b;
      OP_SUB:  raw_sum = ext_a - ext_b;
      default: raw_sum = (DATA_W+1)'(0) - ext_a;
    endcase
    arith_sat = sat_sum(raw_sum);
    stg0_next.func = in_func;
    stg0_next.arith = arith_sat.v;
    stg0_next.arith_st = arith_sat.st;
    stg0_next.prod = prod_t'(in_a) * prod_t'(in_b);
    stg0_next.divz = (in_b == '0);
    stg0_next.minneg = (in_a == WORD_MIN) && (in_b == WORD_NEG_ONE);
    stg0_next.qneg = in_a[DATA_W-1] ^ in_b[DATA_W-1];
    stg0_next.rneg = in_a[DATA_W-1];
    stg0_next.rem = '0;
    stg0_next.dq = in_a[DATA_W-1] ? mag_t'(-in_a) : mag_t'(in_a);
    stg0_next.dvs = in_b[DATA_W-1] ? mag_t'(-in_b) : mag_t'(in_b);
  end

  always_comb begin
    rem_sh = '0;
    rem_diff = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      div_next[k] = stg[k];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        rem_sh = {div_next[k].rem, div_next[k].dq[DATA_W-1]};
        rem_diff = rem_sh - {1'b0, div_next[k].dvs};
        if (!rem_diff[DATA_W]) begin
          div_next[k].rem = rem_diff[DATA_W-1:0];
          div_next[k].dq = {div_next[k].dq[DATA_W-2:0], 1'b1};
        end else begin
          div_next[k].rem = rem_sh[DATA_W-1:0];
          div_next[k].dq = {div_next[k].dq[DATA_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= in_vld;
      for (int k = 0; k < DIV_STAGES; k++) begin
        vld[k+1] <= vld[k];
      end
    end
    stg[0] <= stg0_next;
    for (int k = 0; k < DIV_STAGES; k++) begin
      stg[k+1] <= div_next[k];
    end
  end

  assign prod_sat = sat_prod(stg[DIV_STAGES].prod);
  assign quo = stg[DIV_STAGES].dq;

  always_comb begin
    fin.v = '0;
    fin.st = ST_OK;
    unique case (stg[DIV_STAGES].func)
      OP_ADD, OP_SUB, OP_NEG: begin
        fin.v = stg[DIV_STAGES].arith;
        fin.st = stg[DIV_STAGES].arith_st;
      end
      OP_MUL: begin
        fin = prod_sat;
      end
      OP_DIV, OP_REM: begin
        if (stg[DIV_STAGES].divz) begin
          fin.v = '0;
          fin.st = ST_DIVZERO;
        end else if (stg[DIV_STAGES].minneg) begin
          fin.v = WORD_MIN;
          fin.st = ST_LOW;
        end else if (stg[DIV_STAGES].func == OP_DIV) begin
          fin.v = stg[DIV_STAGES].qneg ? word_t'(-quo) : word_t'(quo);
        end else begin
          fin.v = stg[DIV_STAGES].rneg ? word_t'(-stg[DIV_STAGES].rem)
                                       : word_t'(stg[DIV_STAGES].rem);
        end
      end
      default: begin
        fin.v = '0;
        fin.st = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[DIV_STAGES];
    end
    result <= fin.v;
    status <= fin.st;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("A beat did not leave after the pipeline latency.");

  a_high_is_max: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_HIGH) |-> result == WORD_MAX)
    else $error("High saturation without the maximum value.");

  a_low_is_min: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_LOW) |-> result == WORD_MIN)
    else $error("Low saturation or range error without the minimum value.");

  a_divzero_clear: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DIVZERO) |-> result == '0)
    else $error("Division by zero with a nonzero result.");

endmodule
